[rtl/pia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_pkg
// Shared types and constants for the pulse interval averager.
// ----------------------------------------------------------------------------
package pia_pkg;

  // Default ring depth and fixed field widths.
  localparam int unsigned WINDOW_DEF = 100;
  localparam int unsigned TS_W       = 63;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned AVG_W      = 32;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_CHECK,
    S_DIV,
    S_FINISH
  } pia_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic store;
    logic div_start;
    logic div_step;
    logic take_avg;
    logic load_out;
  } pia_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have_prev;
    logic nonzero;
    logic div_done;
    logic out_free;
  } pia_status_t;

endpackage

[rtl/pia_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_in_if / pia_out_if
// Valid/ready channels for pulse events and averaged results.
// ----------------------------------------------------------------------------
interface pia_in_if;
  logic                       valid;
  logic                       ready;
  logic [pia_pkg::TS_W-1:0]   pulse_stamp;

  modport source (output valid, output pulse_stamp, input ready);
  modport sink   (input valid, input pulse_stamp, output ready);
endinterface

interface pia_out_if;
  logic                       valid;
  logic                       ready;
  logic [pia_pkg::CNT_W-1:0]  pulse_count;
  logic [pia_pkg::AVG_W-1:0]  average_interval_us;
  logic                       average_valid;
  logic [pia_pkg::TS_W-1:0]   last_pulse_time;

  modport source (output valid, output pulse_count, output average_interval_us,
                  output average_valid, output last_pulse_time, input ready);
  modport sink   (input valid, input pulse_count, input average_interval_us,
                  input average_valid, input last_pulse_time, output ready);
endinterface

[rtl/pia_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_ctrl
// Sequencer: accept a pulse, update the ring, run the divider, emit a beat.
// ----------------------------------------------------------------------------
module pia_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pia_pkg::pia_status_t status_i,
  output pia_pkg::pia_cmd_t    cmd_o
);
  import pia_pkg::*;

  pia_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          // The first pulse after reset has no interval to store.
          state_d = status_i.have_prev ? S_STORE : S_FINISH;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        // An all-zero ring keeps the held average.
        if (status_i.nonzero) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.take_avg = 1'b1;
          state_d        = S_FINISH;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/pia_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_datapath
// Interval ring, running sum and count, serial divider and output register.
// ----------------------------------------------------------------------------
module pia_datapath #(
  parameter int unsigned WINDOW = pia_pkg::WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pia_pkg::pia_cmd_t           cmd_i,
  output pia_pkg::pia_status_t        status_o,
  input  logic [pia_pkg::TS_W-1:0]    pulse_stamp_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pia_pkg::CNT_W-1:0]   pulse_count_o,
  output logic [pia_pkg::AVG_W-1:0]   average_interval_us_o,
  output logic                        average_valid_o,
  output logic [pia_pkg::TS_W-1:0]    last_pulse_time_o
);
  import pia_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned NZ_W   = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = AVG_W + NZ_W;
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  // Pulse bookkeeping.
  logic [TS_W-1:0]   prev_q, now_q;
  logic              have_prev_q;
  logic [CNT_W-1:0]  pulse_q;
  logic [AVG_W-1:0]  intv_q, intv_d;
  logic [TS_W-1:0]   diff;

  // Ring storage and its reset-cleared valid bits.
  logic [AVG_W-1:0]  ring_mem [WINDOW];
  logic [AVG_W-1:0]  rd_q;
  logic [WINDOW-1:0] slot_vld_q;
  logic [SLOT_W-1:0] slot_q;
  logic [AVG_W-1:0]  old_val;

  // Running sum and nonzero count.
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [NZ_W-1:0]   nz_q, nz_d;

  // Serial divider.
  logic [SUM_W-1:0]  quo_q;
  logic [NZ_W-1:0]   rem_q;
  logic [NZ_W:0]     rem_sh, rem_d;
  logic [STEP_W-1:0] step_q;
  logic              q_bit;
  logic [AVG_W-1:0]  avg_q;

  // Output register.
  logic              out_vld_q;

  // Interval of the incoming pulse: zero if not later, saturated above 32 bits.
  always_comb begin
    diff = pulse_stamp_i - prev_q;
    if (pulse_stamp_i <= prev_q) begin
      intv_d = '0;
    end else if (diff[TS_W-1:AVG_W] != '0) begin
      intv_d = '1;
    end else begin
      intv_d = diff[AVG_W-1:0];
    end
  end

  // Accept registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      pulse_q     <= '0;
    end else if (cmd_i.accept) begin
      prev_q      <= pulse_stamp_i;
      have_prev_q <= 1'b1;
      pulse_q     <= pulse_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q  <= pulse_stamp_i;
      intv_q <= intv_d;
    end
  end

  // Ring memory: read the outgoing slot on accept, write it on store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= ring_mem[slot_q];
    end
    if (cmd_i.store) begin
      ring_mem[slot_q] <= intv_q;
    end
  end

  assign old_val = slot_vld_q[slot_q] ? rd_q : '0;

  // Sum and count update for the replaced slot.
  always_comb begin
    sum_d = sum_q - SUM_W'(old_val) + SUM_W'(intv_q);
    nz_d  = nz_q - NZ_W'(old_val != '0) + NZ_W'(intv_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      slot_q     <= '0;
      sum_q      <= '0;
      nz_q       <= '0;
    end else if (cmd_i.store) begin
      slot_vld_q[slot_q] <= 1'b1;
      slot_q             <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
      sum_q              <= sum_d;
      nz_q               <= nz_d;
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh = {rem_q, quo_q[SUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, nz_q});
    rem_d  = q_bit ? (rem_sh - {1'b0, nz_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_start) begin
      step_q <= STEP_W'(SUM_W);
    end else if (cmd_i.div_step) begin
      step_q <= step_q - 1'b1;
    end
  end

  // The remainder stays below the divisor, so its top bit is always clear.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], q_bit};
      rem_q <= rem_d[NZ_W-1:0];
    end
  end

  // Held average; the quotient always fits in 32 bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (cmd_i.take_avg) begin
      avg_q <= quo_q[AVG_W-1:0];
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pulse_count_o         <= pulse_q;
      average_interval_us_o <= avg_q;
      average_valid_o       <= (avg_q != '0);
      last_pulse_time_o     <= now_q;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign status_o.have_prev = have_prev_q;
  assign status_o.nonzero   = (nz_q != '0);
  assign status_o.div_done  = (step_q == '0);
  assign status_o.out_free  = !out_vld_q || out_ready_i;

  // The nonzero count never exceeds the ring depth.
  a_nz_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nz_q <= NZ_W'(WINDOW))
    else $error("nonzero slot count exceeds ring depth");

  // The sum is zero exactly when no slot is nonzero.
  a_sum_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nz_q == '0) == (sum_q == '0))
    else $error("interval sum disagrees with nonzero count");

  // The write slot stays inside the ring.
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(WINDOW - 1))
    else $error("write slot out of range");

  // A mean of nonzero intervals is at least one.
  a_avg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_avg |=> (avg_q != '0))
    else $error("computed average is zero");

endmodule

[rtl/pulse_interval_averager_unit.sv]
`timescale 1ns / 1ps
// From accept, the first pulse goes straight to S_FINISH; an all-zero ring passes S_STORE and S_CHECK;
//   otherwise S_STORE, S_CHECK and the serial divider in S_DIV over SUM_W = 32 + clog2(WINDOW + 1) bits.
// A new pulse is taken only after the last one is loaded out; S_FINISH waits while the output is full.
// A finished beat waits in the output register while the next pulse is taken.
// Reset clears the counters, sums and ring valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// pulse_interval_averager_unit
// Moving-average pulse period meter over a ring of WINDOW intervals.
// ----------------------------------------------------------------------------
module pulse_interval_averager_unit #(
  parameter int unsigned WINDOW = pia_pkg::WINDOW_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pia_in_if.sink    in_i,
  pia_out_if.source out_o
);
  import pia_pkg::*;

  pia_cmd_t    cmd;
  pia_status_t status;

  // Sequencer.
  pia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  pia_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .pulse_stamp_i         (in_i.pulse_stamp),
    .out_valid_o           (out_o.valid),
    .out_ready_i           (out_o.ready),
    .pulse_count_o         (out_o.pulse_count),
    .average_interval_us_o (out_o.average_interval_us),
    .average_valid_o       (out_o.average_valid),
    .last_pulse_time_o     (out_o.last_pulse_time)
  );

endmodule
